>>> rtl/core/ppp_pkg.sv
`default_nettype none
package ppp_pkg;

    // Field and datapath widths
    localparam int CoefW  = 32;
    localparam int FracW  = 16;
    localparam int HW     = 66;              // homogeneous sum, Q34.32 signed
    localparam int MagW   = 65;              // magnitude of a sum
    localparam int NW     = MagW + FracW;    // shifted numerator / remainder
    localparam int QBits  = 33;              // quotient bits 32..0
    localparam int CW     = MagW + QBits;    // compare width
    localparam int NRegs  = 6;
    localparam int AddrW  = 6;
    localparam int QDepth = 8;
    localparam int QAW    = 3;
    localparam int OccW   = 4;
    localparam int DivStages = QBits + 2;    // magnitude, range check, one per quotient bit

    // Register indexes
    localparam logic [2:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [2:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [2:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [2:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [2:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [2:0] REG_ROW2_COLS23 = 3'd5;

    // Word passed from the front to the back through the queue
    typedef struct packed {
        logic                 zero;
        logic                 den_neg;
        logic [MagW-1:0]      den;
        logic signed [HW-1:0] h0;
        logic signed [HW-1:0] h1;
    } qword_t;

    // One quotient lane inside the divider pipeline
    typedef struct packed {
        logic            neg;
        logic            ovf;
        logic [NW-1:0]   rem;
        logic [QBits-1:0] quo;
    } lane_t;

    typedef struct packed {
        logic            zero;
        logic [MagW-1:0] den;
        lane_t           u;
        lane_t           v;
    } stage_t;

    // Result flags and coordinates leaving the back end
    typedef struct packed {
        logic [CoefW-1:0] coord;
        logic             sat;
    } clamp_t;

    // One restoring step: compare against the shifted divisor, subtract on hit
    function automatic lane_t lane_step(lane_t l, logic [CW-1:0] dsh);
        logic [CW-1:0] ext;
        logic          ge;
        lane_t         r;
        ext = {{(CW-NW){1'b0}}, l.rem};
        ge  = (ext >= dsh);
        r   = l;
        r.quo = {l.quo[QBits-2:0], ge};
        r.rem = ge ? NW'(ext - dsh) : l.rem;
        return r;
    endfunction

    // Sign and clamp a quotient magnitude to Q16.16
    function automatic clamp_t lane_clamp(lane_t l);
        clamp_t c;
        c.sat = 1'b0;
        if (l.neg) begin
            if (l.ovf || l.quo > QBits'(33'h080000000)) begin
                c.coord = 32'h80000000;
                c.sat   = 1'b1;
            end
            else begin
                c.coord = 32'(-l.quo);
            end
        end
        else begin
            if (l.ovf || l.quo > QBits'(33'h07FFFFFFF)) begin
                c.coord = 32'h7FFFFFFF;
                c.sat   = 1'b1;
            end
            else begin
                c.coord = l.quo[CoefW-1:0];
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/ppp_fifo.sv
`default_nettype none
module ppp_fifo (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire ppp_pkg::qword_t push_word,
    input  wire logic            pop,
    output      ppp_pkg::qword_t pop_word,
    output      logic            empty
);

    ppp_pkg::qword_t                 mem [ppp_pkg::QDepth];
    logic [ppp_pkg::QAW-1:0]         wptr_reg;
    logic [ppp_pkg::QAW-1:0]         rptr_reg;
    logic [ppp_pkg::OccW-1:0]        count_reg;

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wptr_reg] <= push_word;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_reg + ppp_pkg::OccW'(push) - ppp_pkg::OccW'(pop);
        end
    end

    assign pop_word = mem[rptr_reg];
    assign empty    = (count_reg == '0);

endmodule
`default_nettype wire

>>> rtl/core/ppp_front.sv
`default_nettype none
module ppp_front (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ppp_pkg::AddrW-1:0]   paddr,
    input  wire logic [63:0]                 pwdata,
    output      logic [63:0]                 prdata,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire logic signed [31:0]          point_x,
    input  wire logic signed [31:0]          point_y,
    input  wire logic signed [31:0]          point_z,
    input  wire logic                        q_pop,
    output      logic                        q_push,
    output      ppp_pkg::qword_t             q_word
);

    logic [63:0]                  cfg_reg [ppp_pkg::NRegs];
    logic [2:0]                   widx;
    logic                         accept;
    logic [ppp_pkg::OccW-1:0]     occ_reg;
    logic                         p1_valid_reg;
    logic                         p2_valid_reg;
    logic signed [63:0]           prod_reg [3][3];
    logic signed [ppp_pkg::HW-1:0] sum_reg [3];
    logic signed [ppp_pkg::HW-1:0] sum_next [3];
    logic signed [31:0]           coef [3][4];
    logic signed [31:0]           pt [3];
    logic [ppp_pkg::HW-1:0]       h2_neg;

    // Configuration registers
    assign widx = paddr[5:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ppp_pkg::NRegs; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (psel && penable && pwrite && widx < 3'(ppp_pkg::NRegs))
        begin
            cfg_reg[widx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (widx < 3'(ppp_pkg::NRegs))
        begin
            prdata = cfg_reg[widx];
        end
    end

    // Coefficient unpacking: even column in the upper half
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                coef[r][c] = (c % 2 == 0) ? cfg_reg[r*2 + c/2][63:32]
                                          : cfg_reg[r*2 + c/2][31:0];
            end
        end
    end

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    // Credit: items in the front stages plus those queued
    assign in_ready = (occ_reg < ppp_pkg::OccW'(ppp_pkg::QDepth));
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg      <= '0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg      <= occ_reg + ppp_pkg::OccW'(accept) - ppp_pkg::OccW'(q_pop);
            p1_valid_reg <= accept;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    // Stage 1: nine products
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_reg[r][c] <= coef[r][c] * pt[c];
            end
        end
    end

    // Stage 2: exact Q34.32 sums
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = {{(ppp_pkg::HW-48){coef[r][3][31]}}, coef[r][3], 16'b0}
                        + {{2{prod_reg[r][0][63]}}, prod_reg[r][0]}
                        + {{2{prod_reg[r][1][63]}}, prod_reg[r][1]}
                        + {{2{prod_reg[r][2][63]}}, prod_reg[r][2]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_reg[r] <= sum_next[r];
        end
    end

    // Classify depth: zero test, sign and magnitude
    assign h2_neg = -sum_reg[2];

    always_comb
    begin
        q_word.zero    = (sum_reg[2] == '0);
        q_word.den_neg = sum_reg[2][ppp_pkg::HW-1];
        q_word.den     = sum_reg[2][ppp_pkg::HW-1] ? h2_neg[ppp_pkg::MagW-1:0]
                                                   : sum_reg[2][ppp_pkg::MagW-1:0];
        q_word.h0      = sum_reg[0];
        q_word.h1      = sum_reg[1];
    end

    assign q_push = p2_valid_reg;

endmodule
`default_nettype wire

>>> rtl/core/ppp_back.sv
`default_nettype none
module ppp_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_empty,
    input  wire ppp_pkg::qword_t    q_word,
    output      logic               q_pop,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] image_u,
    output      logic signed [31:0] image_v,
    output      logic               at_infinity,
    output      logic               saturated
);

    localparam int NS = ppp_pkg::DivStages;

    logic                 en;
    logic                 valid_reg [NS];
    ppp_pkg::stage_t      st_reg [NS];
    ppp_pkg::stage_t      st0_next;
    logic [ppp_pkg::HW-1:0] n0_neg;
    logic [ppp_pkg::HW-1:0] n1_neg;
    logic [ppp_pkg::MagW-1:0] m0;
    logic [ppp_pkg::MagW-1:0] m1;
    logic                 out_valid_reg;
    logic [31:0]          u_reg;
    logic [31:0]          v_reg;
    logic                 inf_reg;
    logic                 sat_reg;
    ppp_pkg::clamp_t      cu;
    ppp_pkg::clamp_t      cv;

    // Whole pipeline moves unless the output word is held
    assign en    = !out_valid_reg || out_ready;
    assign q_pop = en && !q_empty;

    // Stage 0: numerator magnitudes and quotient signs
    assign n0_neg = -q_word.h0;
    assign n1_neg = -q_word.h1;
    assign m0 = q_word.h0[ppp_pkg::HW-1] ? n0_neg[ppp_pkg::MagW-1:0]
                                         : q_word.h0[ppp_pkg::MagW-1:0];
    assign m1 = q_word.h1[ppp_pkg::HW-1] ? n1_neg[ppp_pkg::MagW-1:0]
                                         : q_word.h1[ppp_pkg::MagW-1:0];

    always_comb
    begin
        st0_next.zero  = q_word.zero;
        st0_next.den   = q_word.den;
        st0_next.u.neg = q_word.h0[ppp_pkg::HW-1] ^ q_word.den_neg;
        st0_next.u.ovf = 1'b0;
        st0_next.u.rem = {m0, {ppp_pkg::FracW{1'b0}}};
        st0_next.u.quo = '0;
        st0_next.v.neg = q_word.h1[ppp_pkg::HW-1] ^ q_word.den_neg;
        st0_next.v.ovf = 1'b0;
        st0_next.v.rem = {m1, {ppp_pkg::FracW{1'b0}}};
        st0_next.v.quo = '0;
    end

    // Valid bits of the divider stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NS; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= !q_empty;
            for (int k = 1; k < NS; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0] <= st0_next;
        end
    end

    // Stage 1: quotient at or above 2^33 is out of range outright
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[1].zero  <= st_reg[0].zero;
            st_reg[1].den   <= st_reg[0].den;
            st_reg[1].u.neg <= st_reg[0].u.neg;
            st_reg[1].u.rem <= st_reg[0].u.rem;
            st_reg[1].u.quo <= st_reg[0].u.quo;
            st_reg[1].v.neg <= st_reg[0].v.neg;
            st_reg[1].v.rem <= st_reg[0].v.rem;
            st_reg[1].v.quo <= st_reg[0].v.quo;
            st_reg[1].u.ovf <= ({{(ppp_pkg::CW-ppp_pkg::NW){1'b0}}, st_reg[0].u.rem}
                                >= {st_reg[0].den, {ppp_pkg::QBits{1'b0}}});
            st_reg[1].v.ovf <= ({{(ppp_pkg::CW-ppp_pkg::NW){1'b0}}, st_reg[0].v.rem}
                                >= {st_reg[0].den, {ppp_pkg::QBits{1'b0}}});
        end
    end

    // One quotient bit per stage, most significant first
    for (genvar k = 2; k < NS; k++)
    begin : g_bit
        localparam int BI = NS - 1 - k;
        logic [ppp_pkg::CW-1:0] dsh;

        assign dsh = ppp_pkg::CW'({{(ppp_pkg::CW-ppp_pkg::MagW){1'b0}}, st_reg[k-1].den}
                     << BI);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[k].zero <= st_reg[k-1].zero;
                st_reg[k].den  <= st_reg[k-1].den;
                st_reg[k].u    <= ppp_pkg::lane_step(st_reg[k-1].u, dsh);
                st_reg[k].v    <= ppp_pkg::lane_step(st_reg[k-1].v, dsh);
            end
        end
    end

    // Sign, clamp and output register
    assign cu = ppp_pkg::lane_clamp(st_reg[NS-1].u);
    assign cv = ppp_pkg::lane_clamp(st_reg[NS-1].v);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[NS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (st_reg[NS-1].zero)
            begin
                u_reg   <= '0;
                v_reg   <= '0;
                inf_reg <= 1'b1;
                sat_reg <= 1'b0;
            end
            else
            begin
                u_reg   <= cu.coord;
                v_reg   <= cv.coord;
                inf_reg <= 1'b0;
                sat_reg <= cu.sat || cv.sat;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign image_u     = u_reg;
    assign image_v     = v_reg;
    assign at_infinity = inf_reg;
    assign saturated   = sat_reg;

endmodule
`default_nettype wire

>>> rtl/core/pinhole_point_projection_top.sv
`default_nettype none
// Pinhole projection of Q16.16 points through a 3x4 matrix held in six 64-bit
// APB registers (byte address 8*i, even column in the upper word). One point
// is accepted per clock while in_ready is high. Points pass two multiply/sum
// stages, the eight-word queue and a 35-stage divider (magnitude, range
// check, then one quotient bit per stage for u and v side by side). The queue
// absorbs output stalls until front and queue hold eight points. Zero depth
// gives u = v = 0 with at_infinity set; quotients beyond the Q16.16 range
// clamp and set saturated. Write registers only while idle.
module pinhole_point_projection_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [5:0]         paddr,
    input  wire logic [63:0]        pwdata,
    output      logic [63:0]        prdata,
    output      logic               pready,
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic signed [31:0] point_x,
    input  wire logic signed [31:0] point_y,
    input  wire logic signed [31:0] point_z,
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] image_u,
    output      logic signed [31:0] image_v,
    output      logic               at_infinity,
    output      logic               saturated
);

    logic            q_push;
    logic            q_pop;
    logic            q_empty;
    ppp_pkg::qword_t push_word;
    ppp_pkg::qword_t pop_word;

    assign pready = 1'b1;

    ppp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .q_pop    (q_pop),
        .q_push   (q_push),
        .q_word   (push_word)
    );

    ppp_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (push_word),
        .pop       (q_pop),
        .pop_word  (pop_word),
        .empty     (q_empty)
    );

    ppp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_word      (pop_word),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .image_u     (image_u),
        .image_v     (image_v),
        .at_infinity (at_infinity),
        .saturated   (saturated)
    );

endmodule
`default_nettype wire
